### design/fca_pkg.sv
// Shared constants for the flagged channel averager.
`timescale 1ns / 1ps
`default_nettype none
package fca_pkg;
  localparam int unsigned SIGMA_W = 32;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned VAR_W   = 64;
  localparam int unsigned ROOT_W  = 32;
endpackage
`default_nettype wire

### design/fca_if.sv
// Valid/ready stream interface carrying one averager word.
`timescale 1ns / 1ps
`default_nettype none
interface fca_if #(
  parameter int unsigned SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] vis_real;
  logic signed [SAMPLE_BITS-1:0] vis_imag;
  logic                          flagged;
  logic [31:0]                   sigma;
  modport source (output valid, vis_real, vis_imag, flagged, sigma, input ready);
  modport sink   (input valid, vis_real, vis_imag, flagged, sigma, output ready);
endinterface

interface fca_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### design/flagged_channel_averager.sv
// Top level: flag-aware channel averager.
// A width-1 word passes through the front register and the back's output state; a group
// result follows its last word through 32 root steps and ACC_W divide steps, unless the
// group is fully flagged. The back handles one word or group at a time, so groups shorter
// than the back's processing stall the input.
// Reset clears group state and sets the group width to 1.
`timescale 1ns / 1ps
`default_nettype none
module flagged_channel_averager import fca_pkg::*; #(
  parameter int unsigned MAX_GROUP_WIDTH = 64,
  parameter int unsigned SAMPLE_BITS     = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fca_cfg_if.sink   cfg,
  fca_if.sink       in_w,
  fca_if.source     out_w
);
  localparam int unsigned CNT_W = $clog2(MAX_GROUP_WIDTH + 1);
  localparam int unsigned ACC_W = SAMPLE_BITS + CNT_W;
  logic q_valid, q_ready, q_pass, q_flag;
  logic signed [ACC_W-1:0] q_real, q_imag;
  logic [VAR_W-1:0] q_var;
  logic [CNT_W-1:0] q_cnt;
  logic [SIGMA_W-1:0] q_sigma;

  assign cfg.ready = 1'b1;

  fca_front #(.MAX_GROUP_WIDTH(MAX_GROUP_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg.valid), .cfg_data_i(cfg.data),
    .in_valid_i(in_w.valid), .in_ready_o(in_w.ready),
    .in_real_i(in_w.vis_real), .in_imag_i(in_w.vis_imag),
    .in_flag_i(in_w.flagged), .in_sigma_i(in_w.sigma),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_pass_o(q_pass),
    .q_real_o(q_real), .q_imag_o(q_imag), .q_var_o(q_var), .q_cnt_o(q_cnt),
    .q_sigma_o(q_sigma), .q_flag_o(q_flag)
  );

  fca_back #(.MAX_GROUP_WIDTH(MAX_GROUP_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_pass_i(q_pass),
    .q_real_i(q_real), .q_imag_i(q_imag), .q_var_i(q_var), .q_cnt_i(q_cnt),
    .q_sigma_i(q_sigma), .q_flag_i(q_flag),
    .out(out_w)
  );
endmodule
`default_nettype wire

### design/fca_front.sv
// Front end: group accumulation of real, imaginary and variance sums, or passthrough at width 1.
`timescale 1ns / 1ps
`default_nettype none
module fca_front import fca_pkg::*; #(
  parameter int unsigned MAX_GROUP_WIDTH = 64,
  parameter int unsigned SAMPLE_BITS     = 32,
  localparam int unsigned CNT_W = $clog2(MAX_GROUP_WIDTH + 1),
  localparam int unsigned ACC_W = SAMPLE_BITS + CNT_W
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] in_real_i,
  input  wire logic signed [SAMPLE_BITS-1:0] in_imag_i,
  input  wire logic                    in_flag_i,
  input  wire logic [SIGMA_W-1:0]      in_sigma_i,
  output logic                         q_valid_o,
  input  wire logic                    q_ready_i,
  output logic                         q_pass_o,
  output logic signed [ACC_W-1:0]      q_real_o,
  output logic signed [ACC_W-1:0]      q_imag_o,
  output logic [VAR_W-1:0]             q_var_o,
  output logic [CNT_W-1:0]             q_cnt_o,
  output logic [SIGMA_W-1:0]           q_sigma_o,
  output logic                         q_flag_o
);
  logic [CNT_W-1:0] width_q, pos_q, good_q;
  logic signed [ACC_W-1:0] re_q, im_q;
  logic [VAR_W-1:0] var_q;
  logic [CNT_W-1:0] wsat;
  logic [VAR_W-1:0] sq;
  logic [VAR_W:0] vsum;
  logic take, last;

  always_comb begin
    if (cfg_data_i == '0) wsat = CNT_W'(1);
    else if ({25'd0, cfg_data_i} > 32'(MAX_GROUP_WIDTH)) wsat = CNT_W'(MAX_GROUP_WIDTH);
    else wsat = CNT_W'(cfg_data_i);
  end

  assign in_ready_o = !q_valid_o || q_ready_i;
  assign take = in_valid_i && in_ready_o;
  assign sq   = {32'd0, in_sigma_i} * {32'd0, in_sigma_i};
  assign vsum = {1'b0, var_q} + {1'b0, sq};
  assign last = (pos_q + CNT_W'(1)) >= width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= CNT_W'(1);
      pos_q <= '0; good_q <= '0; re_q <= '0; im_q <= '0; var_q <= '0;
      q_valid_o <= 1'b0;
    end else begin
      if (q_ready_i) q_valid_o <= 1'b0;
      if (cfg_we_i) begin
        width_q <= wsat;
        pos_q <= '0; good_q <= '0; re_q <= '0; im_q <= '0; var_q <= '0;
      end else if (take) begin
        if (width_q == CNT_W'(1)) begin
          q_valid_o <= 1'b1;
          q_pass_o <= 1'b1;
          q_real_o <= ACC_W'(in_real_i);
          q_imag_o <= ACC_W'(in_imag_i);
          q_flag_o <= in_flag_i;
          q_sigma_o <= in_sigma_i;
        end else if (last) begin
          q_valid_o <= 1'b1;
          q_pass_o <= 1'b0;
          q_real_o <= in_flag_i ? re_q : re_q + ACC_W'(in_real_i);
          q_imag_o <= in_flag_i ? im_q : im_q + ACC_W'(in_imag_i);
          q_var_o  <= in_flag_i ? var_q : (vsum[VAR_W] ? '1 : vsum[VAR_W-1:0]);
          q_cnt_o  <= in_flag_i ? good_q : good_q + CNT_W'(1);
          q_flag_o <= in_flag_i && (good_q == '0);
          q_sigma_o <= in_sigma_i;
          pos_q <= '0; good_q <= '0; re_q <= '0; im_q <= '0; var_q <= '0;
        end else begin
          pos_q <= pos_q + CNT_W'(1);
          if (!in_flag_i) begin
            re_q <= re_q + ACC_W'(in_real_i);
            im_q <= im_q + ACC_W'(in_imag_i);
            var_q <= vsum[VAR_W] ? '1 : vsum[VAR_W-1:0];
            good_q <= good_q + CNT_W'(1);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/fca_back.sv
// Back end: iterative root and rounded divisions for one group; pass-through and fully flagged results skip them.
`timescale 1ns / 1ps
`default_nettype none
module fca_back import fca_pkg::*; #(
  parameter int unsigned MAX_GROUP_WIDTH = 64,
  parameter int unsigned SAMPLE_BITS     = 32,
  localparam int unsigned CNT_W = $clog2(MAX_GROUP_WIDTH + 1),
  localparam int unsigned ACC_W = SAMPLE_BITS + CNT_W
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_valid_i,
  output logic                         q_ready_o,
  input  wire logic                    q_pass_i,
  input  wire logic signed [ACC_W-1:0] q_real_i,
  input  wire logic signed [ACC_W-1:0] q_imag_i,
  input  wire logic [VAR_W-1:0]        q_var_i,
  input  wire logic [CNT_W-1:0]        q_cnt_i,
  input  wire logic [SIGMA_W-1:0]      q_sigma_i,
  input  wire logic                    q_flag_i,
  fca_if.source                        out
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_ROOT = 4'b0010, S_DIV = 4'b0100, S_OUT = 4'b1000
  } state_e;
  localparam int unsigned RC_W = $clog2(ROOT_W);
  localparam int unsigned DC_W = $clog2(ACC_W + 1);

  state_e st_q;
  logic [VAR_W-1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [VAR_W+1:0] racc_q;
  logic [RC_W-1:0] rcnt_q;
  logic [ACC_W-1:0] nre_q, nim_q, nsg_q, qre_q, qim_q, qsg_q;
  logic [CNT_W-1:0] rre_q, rim_q, rsg_q, n_q;
  logic [DC_W-1:0] dcnt_q;
  logic sre_q, sim_q;
  logic [VAR_W+1:0] racc_d, trial;
  logic [CNT_W:0] tre, tim, tsg;
  logic [ACC_W-1:0] are, aim;

  assign q_ready_o = (st_q == S_IDLE);
  assign out.valid = (st_q == S_OUT);
  assign are = q_real_i[ACC_W-1] ? ACC_W'(-q_real_i) : ACC_W'(q_real_i);
  assign aim = q_imag_i[ACC_W-1] ? ACC_W'(-q_imag_i) : ACC_W'(q_imag_i);
  assign racc_d = {racc_q[VAR_W-1:0], rem_q[VAR_W-1 -: 2]};
  assign trial  = racc_d - {{(VAR_W-ROOT_W){1'b0}}, root_q, 2'b01};
  assign tre = {rre_q, nre_q[ACC_W-1]} - {1'b0, n_q};
  assign tim = {rim_q, nim_q[ACC_W-1]} - {1'b0, n_q};
  assign tsg = {rsg_q, nsg_q[ACC_W-1]} - {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (q_pass_i || q_flag_i) begin
              st_q <= S_OUT;
              qre_q <= q_pass_i ? ACC_W'(q_real_i) : '0;
              qim_q <= q_pass_i ? ACC_W'(q_imag_i) : '0;
              qsg_q <= q_pass_i ? ACC_W'(q_sigma_i) : '0;
              sre_q <= 1'b0; sim_q <= 1'b0;
              out.flagged <= q_flag_i;
            end else begin
              st_q <= S_ROOT;
              n_q <= q_cnt_i;
              sre_q <= q_real_i[ACC_W-1];
              sim_q <= q_imag_i[ACC_W-1];
              nre_q <= are + ACC_W'(q_cnt_i >> 1);
              nim_q <= aim + ACC_W'(q_cnt_i >> 1);
              rem_q <= q_var_i; root_q <= '0; racc_q <= '0; rcnt_q <= '0;
              out.flagged <= 1'b0;
            end
          end
        end
        S_ROOT: begin
          rem_q <= rem_q << 2;
          if (!trial[VAR_W+1]) begin
            racc_q <= trial; root_q <= {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            racc_q <= racc_d; root_q <= {root_q[ROOT_W-2:0], 1'b0};
          end
          rcnt_q <= rcnt_q + RC_W'(1);
          if (rcnt_q == RC_W'(ROOT_W - 1)) begin
            st_q <= S_DIV; dcnt_q <= '0;
            rre_q <= '0; rim_q <= '0; rsg_q <= '0;
            nsg_q <= ACC_W'({1'b0, root_q[ROOT_W-2:0], ~trial[VAR_W+1]}) +
                     ACC_W'(n_q >> 1);
          end
        end
        S_DIV: begin
          nre_q <= {nre_q[ACC_W-2:0], ~tre[CNT_W]};
          nim_q <= {nim_q[ACC_W-2:0], ~tim[CNT_W]};
          nsg_q <= {nsg_q[ACC_W-2:0], ~tsg[CNT_W]};
          rre_q <= tre[CNT_W] ? {rre_q[CNT_W-2:0], nre_q[ACC_W-1]} : tre[CNT_W-1:0];
          rim_q <= tim[CNT_W] ? {rim_q[CNT_W-2:0], nim_q[ACC_W-1]} : tim[CNT_W-1:0];
          rsg_q <= tsg[CNT_W] ? {rsg_q[CNT_W-2:0], nsg_q[ACC_W-1]} : tsg[CNT_W-1:0];
          dcnt_q <= dcnt_q + DC_W'(1);
          if (dcnt_q == DC_W'(ACC_W - 1)) begin
            st_q <= S_OUT;
            qre_q <= {nre_q[ACC_W-2:0], ~tre[CNT_W]};
            qim_q <= {nim_q[ACC_W-2:0], ~tim[CNT_W]};
            qsg_q <= {nsg_q[ACC_W-2:0], ~tsg[CNT_W]};
          end
        end
        S_OUT: begin
          rcnt_q <= '0;
          if (out.ready) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out.vis_real = sre_q ? SAMPLE_BITS'(-qre_q) : SAMPLE_BITS'(qre_q);
    out.vis_imag = sim_q ? SAMPLE_BITS'(-qim_q) : SAMPLE_BITS'(qim_q);
    out.sigma    = qsg_q[SIGMA_W-1:0];
  end
endmodule
`default_nettype wire

### bench/flagged_channel_averager_tb.sv
// Self-checking bench for the flagged channel averager: queued stimulus, predictor, monitor.
`timescale 1ns / 1ps
`default_nettype none
module flagged_channel_averager_tb;
  import fca_pkg::*;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               flag;
    logic [31:0]        sigma;
  } word_t;

  typedef struct packed {
    logic       is_cfg;
    logic [6:0] width;
    word_t      w;
  } op_t;

  logic clk_i;
  logic rst_ni;

  fca_cfg_if cfg ();
  fca_if #(.SAMPLE_BITS(32)) in_w ();
  fca_if #(.SAMPLE_BITS(32)) out_w ();

  flagged_channel_averager #(.MAX_GROUP_WIDTH(64), .SAMPLE_BITS(32)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg),
    .in_w  (in_w),
    .out_w (out_w)
  );

  op_t   pending_q[$];
  word_t averages_q[$];
  int    errors;
  int    stall_left, sink_stall_left, idle_cycles, results_seen;
  bit    calm;
  bit    in_hold, cfg_hold;

  // predictor state
  int unsigned      width_r;
  int unsigned      pos_r, good_r;
  longint           re_acc, im_acc;
  longint unsigned  var_acc;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] round_mean(longint s, int unsigned n);
    longint unsigned m, q;
    if (s >= 0) begin
      q = (longint'(s) + n / 2) / n;
      return q[31:0];
    end
    m = 64'd0 - longint'(s);
    q = (m + n / 2) / n;
    q = 64'd0 - q;
    return q[31:0];
  endfunction

  task automatic average_word(input word_t w);
    word_t r;
    int unsigned ew;
    longint unsigned sq, rt;
    ew = (width_r == 0) ? 1 : (width_r > 64 ? 64 : width_r);
    if (ew == 1) begin
      averages_q = {averages_q, w};
      return;
    end
    if (!w.flag) begin
      sq = longint'(w.sigma) * longint'(w.sigma);
      re_acc += longint'(w.re);
      im_acc += longint'(w.im);
      var_acc = (var_acc > ~64'd0 - sq) ? ~64'd0 : var_acc + sq;
      good_r++;
    end
    pos_r++;
    if (pos_r < ew) return;
    if (good_r == 0) begin
      r = '0;
      r.flag = 1'b1;
    end else begin
      rt = root64(var_acc);
      r.re = round_mean(re_acc, good_r);
      r.im = round_mean(im_acc, good_r);
      r.flag = 1'b0;
      rt = (rt + good_r / 2) / good_r;
      r.sigma = rt[31:0];
    end
    averages_q = {averages_q, r};
    pos_r = 0; good_r = 0; re_acc = 0; im_acc = 0; var_acc = 0;
  endtask

  function automatic word_t rand_word(int mode);
    word_t w;
    w.re = $urandom;
    w.im = $urandom;
    w.flag = ($urandom_range(0, 3) == 0);
    w.sigma = $urandom;
    if (mode == 1) begin
      w.re = $signed($urandom_range(0, 4095)) - 2048;
      w.im = $signed($urandom_range(0, 4095)) - 2048;
      w.sigma = $urandom_range(0, 65535);
    end
    return w;
  endfunction

  function automatic word_t mk(logic [31:0] re, logic [31:0] im, logic f, logic [31:0] s);
    word_t w;
    w.re = re; w.im = im; w.flag = f; w.sigma = s;
    return w;
  endfunction

  task automatic add_cfg(input logic [6:0] v);
    op_t o;
    o = '0;
    o.is_cfg = 1'b1;
    o.width = v;
    pending_q = {pending_q, o};
  endtask

  task automatic add_word(input word_t w);
    op_t o;
    o = '0;
    o.w = w;
    pending_q = {pending_q, o};
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int n, widths[$];
    rst_ni = 1'b0;
    // directed: passthrough extremes, including flagged words
    add_word(mk(32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'hffff_ffff));
    add_word(mk(32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h0));
    add_word(mk(32'h0, 32'hffff_ffff, 1'b0, 32'h1));
    // width 0 acts as 1
    add_cfg(7'd0);
    add_word(mk(32'h1234_5678, 32'hfedc_ba98, 1'b1, 32'h0001_0000));
    // width 2: ties both signs, fully flagged group, variance saturation
    add_cfg(7'd2);
    add_word(mk(32'd1, 32'hffff_ffff, 1'b0, 32'h0));
    add_word(mk(32'd0, 32'h0, 1'b0, 32'h0));
    add_word(mk(32'd5, 32'd5, 1'b1, 32'd9));
    add_word(mk(32'd5, 32'd5, 1'b1, 32'd9));
    add_word(mk(32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'hffff_ffff));
    add_word(mk(32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'hffff_ffff));
    // width above max saturates; write mid-group clears it
    add_cfg(7'd3);
    add_word(mk(32'd7, 32'd7, 1'b0, 32'd7));
    add_cfg(7'd127);
    for (int i = 0; i < 64; i++) add_word(rand_word(i % 2));
    add_cfg(7'd64);
    for (int i = 0; i < 64; i++) add_word(mk(32'd0, 32'd0, 1'b1, 32'd0));
    widths = '{1, 2, 3, 4, 5, 7, 8, 16, 2, 1, 3};
    n = 0;
    while (n < 610) begin
      int gw;
      gw = (n > 520) ? 2 : widths[$urandom_range(0, widths.size() - 1)];
      if ($urandom_range(0, 9) == 0) gw = $urandom_range(0, 127);
      add_cfg(gw[6:0]);
      for (int k = 0; k < 20 + $urandom_range(0, 30); k++) begin
        add_word(rand_word($urandom_range(0, 1)));
        n++;
      end
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // word still waiting at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_hold <= 1'b0;
      cfg_hold <= 1'b0;
    end else begin
      in_hold <= in_w.valid && !in_w.ready;
      cfg_hold <= cfg.valid && !cfg.ready;
    end
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_w.valid <= 1'b0; in_w.vis_real <= '0; in_w.vis_imag <= '0;
      in_w.flagged <= 1'b0; in_w.sigma <= '0;
      cfg.valid <= 1'b0; cfg.data <= 7'd1;
      stall_left <= 0;
    end else if (in_hold || cfg_hold) begin
      // hold
    end else if (stall_left > 0) begin
      in_w.valid <= 1'b0; cfg.valid <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pending_q.size() == 0) begin
      in_w.valid <= 1'b0; cfg.valid <= 1'b0;
    end else if (pending_q[0].is_cfg) begin
      in_w.valid <= 1'b0;
      // wait for idle and drain before a register write
      if (averages_q.size() == 0 && !cfg.valid) begin
        if (idle_cycles < 120) begin
          cfg.valid <= 1'b0;
        end else begin
          cfg.data <= pending_q[0].width;
          cfg.valid <= 1'b1;
          width_r = pending_q[0].width;
          pos_r = 0; good_r = 0; re_acc = 0; im_acc = 0; var_acc = 0;
          void'(pending_q.pop_front());
        end
      end else begin
        cfg.valid <= 1'b0;
      end
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      in_w.valid <= 1'b0; cfg.valid <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      cfg.valid <= 1'b0;
      in_w.valid <= 1'b1;
      in_w.vis_real <= pending_q[0].w.re;
      in_w.vis_imag <= pending_q[0].w.im;
      in_w.flagged <= pending_q[0].w.flag;
      in_w.sigma <= pending_q[0].w.sigma;
      average_word(pending_q[0].w);
      void'(pending_q.pop_front());
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_w.ready <= 1'b0;
      sink_stall_left <= 0;
    end else if (sink_stall_left > 0) begin
      out_w.ready <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (!calm && $urandom_range(0, 12) == 0) begin
      out_w.ready <= 1'b0;
      sink_stall_left <= $urandom_range(0, 18);
    end else begin
      out_w.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_w.valid && in_w.ready) || (cfg.valid && cfg.ready) ||
          (out_w.valid && out_w.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_w.valid && out_w.ready) begin
        results_seen <= results_seen + 1;
        if (averages_q.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          word_t e;
          e = averages_q.pop_front();
          if (out_w.vis_real !== e.re) begin
            $error("avg_real exp %h got %h", e.re, out_w.vis_real); errors++;
          end
          if (out_w.vis_imag !== e.im) begin
            $error("avg_imag exp %h got %h", e.im, out_w.vis_imag); errors++;
          end
          if (out_w.flagged !== e.flag) begin
            $error("avg_flagged exp %b got %b", e.flag, out_w.flagged); errors++;
          end
          if (out_w.sigma !== e.sigma) begin
            $error("avg_sigma exp %h got %h", e.sigma, out_w.sigma); errors++;
          end
        end
      end
      if (idle_cycles > 20000) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("flagged_channel_averager regression: fail");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; results_seen = 0; calm = 1'b0;
    width_r = 1; pos_r = 0; good_r = 0; re_acc = 0; im_acc = 0; var_acc = 0;
    @(posedge rst_ni);
    wait (pending_q.size() < 120);
    calm = 1'b1;
    wait (pending_q.size() == 0 && !in_w.valid && !cfg.valid);
    wait (averages_q.size() == 0);
    repeat (150) @(posedge clk_i);
    if (averages_q.size() != 0) begin
      $error("%0d expected results never arrived", averages_q.size());
      errors++;
    end
    $display("covered widths 0..127 with flagged, saturating and tie-rounding groups");
    $display("%0d result words checked, %0d errors", results_seen, errors);
    if (errors == 0) begin
      $display("flagged_channel_averager regression: pass");
    end else begin
      $display("flagged_channel_averager regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
